### sv/nor_flash_command_sequencer_macros.svh
// assertion macros for the nor flash command sequencer checker
// expects clk and rst in the scope where a macro is used
`ifndef NOR_FLASH_COMMAND_SEQUENCER_MACROS_SVH
`define NOR_FLASH_COMMAND_SEQUENCER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define NFCS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nfcs check failed");

// antecedent implies consequent in the next cycle
`define NFCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nfcs check failed");

`endif

### sv/nfcs_pkg.sv
// shared types, codes and constants of the nor flash command sequencer
// no dependencies
`default_nettype none

package nfcs_pkg;

  // byte offset bits taken from the input item
  localparam int OFFSET_BITS = 25;
  localparam int OFFSET_W    = 25;
  localparam int ADDR_W      = 24;
  localparam int DATA_W      = 32;
  localparam logic [OFFSET_W-1:0] OFFSET_MASK =
    (OFFSET_BITS >= OFFSET_W) ? {OFFSET_W{1'b1}}
                              : OFFSET_W'((64'd1 << OFFSET_BITS) - 64'd1);

  localparam logic [ADDR_W-1:0] ADDR_UNLOCK1 = 24'h000555;
  localparam logic [ADDR_W-1:0] ADDR_UNLOCK2 = 24'h0002aa;
  localparam logic [ADDR_W-1:0] ADDR_MAX     = 24'hffffff;
  localparam logic [23:0] TIMEOUT_DEFAULT    = 24'd10000000;

  typedef enum logic [2:0] {
    MODE_RESET       = 3'd0,
    MODE_CHIP_ERASE  = 3'd1,
    MODE_SECT_ERASE  = 3'd2,
    MODE_PROGRAM     = 3'd3,
    MODE_POLL        = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_ISSUED  = 3'd0,
    ST_BUSY    = 3'd1,
    ST_DONE    = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_REFUSED = 3'd4,
    ST_IDLE    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_ERASE   = 2'd1,
    KIND_PROGRAM = 2'd2
  } kind_t;

  // bus width codes
  localparam logic [1:0] BW_8  = 2'd0;
  localparam logic [1:0] BW_16 = 2'd1;
  localparam logic [1:0] BW_32 = 2'd2;

  // register indexes
  localparam logic [1:0] REG_BUS_WIDTH = 2'd0;
  localparam logic [1:0] REG_DEV_SIZE  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT   = 2'd2;

  typedef struct packed {
    logic [1:0]  bus_width;
    logic [4:0]  device_size_log2;
    logic [23:0] timeout_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [ADDR_W-1:0] word;
    logic [15:0]       write_data;
    logic [31:0]       read_first;
    logic [31:0]       read_second;
  } item_t;

  typedef struct packed {
    kind_t             kind;
    logic [31:0]       expected_value;
    logic [23:0]       poll_count;
    logic [ADDR_W-1:0] poll_address;
  } state_t;

  typedef struct packed {
    logic              bus_write;
    logic [ADDR_W-1:0] bus_addr;
    logic [DATA_W-1:0] bus_data;
    status_t           status;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

### sv/nor_flash_command_sequencer.sv
// top level of the nor flash command sequencer: item register, step counter,
// result register and configuration; depends on nfcs_pkg and nfcs_step
//
// usage
//   s_* takes one item per transfer: a command (reset, chip erase, sector
//   erase, program word) or a poll carrying two status reads
//   m_* gives the results: each command gives its bus writes in order, the
//   final one flagged by m_tlast; every other item gives a single result
//   cfg_* writes a register (0 bus width, 1 device size log2, 2 timeout
//   limit); cfg_ready is always high, write only while the block is idle
// path: an item is registered in the item register and its first result in the
//   result register before it appears on m_* when the output is free
// throughput: one result per cycle while m_tready allows; an item holds the
//   item register until its final result moves on, and it has 1 to 6 results
//   (a chip or sector erase gives 6); the next item is taken in the cycle its
//   predecessor's final result moves into the result register
// reset: clears the registers to their defaults, nothing pending
// stall: when m_tready is low the result register holds, the step counter
//   stops and s_tready drops once the item register is full
`default_nettype none

module nor_flash_command_sequencer (
  input  logic         clk,
  input  logic         rst,
  // item stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,   // byte_offset, write_data, read_first, read_second
  input  logic [2:0]   s_tuser,   // mode
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [55:0]  m_tdata,   // bus_addr, bus_data
  output logic [3:0]   m_tuser,   // bus_write, status
  output logic         m_tlast,
  // register writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  // configuration registers
  nfcs_pkg::cfg_t    cfg;
  // operation state left by the last item
  nfcs_pkg::state_t  st;
  nfcs_pkg::state_t  st_next;

  // held item and its step
  logic              hold_valid;
  nfcs_pkg::item_t   hold;
  logic [2:0]        step;

  // result register
  logic              out_valid;
  nfcs_pkg::result_t out;

  nfcs_pkg::result_t res;
  nfcs_pkg::item_t   in_item;
  logic [24:0]       offset_masked;
  logic              advance;
  logic              item_done;
  logic              in_xfer;

  nfcs_step u_step (
    .item    (hold),
    .step    (step),
    .cfg     (cfg),
    .st      (st),
    .res     (res),
    .st_next (st_next)
  );

  // unpack the item, byte offset becomes a word index
  assign offset_masked       = s_tdata[24:0] & nfcs_pkg::OFFSET_MASK;
  assign in_item.mode        = s_tuser;
  assign in_item.word        = offset_masked[24:1];
  assign in_item.write_data  = s_tdata[40:25];
  assign in_item.read_first  = s_tdata[72:41];
  assign in_item.read_second = s_tdata[104:73];

  // a result moves into the result register when it is free or drains now
  assign advance   = hold_valid && (!out_valid || m_tready);
  assign item_done = advance && res.last;
  assign s_tready  = !hold_valid || item_done;
  assign in_xfer   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      step       <= 3'd0;
      out_valid  <= 1'b0;
      cfg        <= '{bus_width: nfcs_pkg::BW_16, device_size_log2: 5'd0,
                      timeout_limit: nfcs_pkg::TIMEOUT_DEFAULT};
      st         <= '{kind: nfcs_pkg::KIND_NONE, expected_value: 32'd0,
                      poll_count: 24'd0, poll_address: '0};
    end else begin
      if (in_xfer) begin
        hold_valid <= 1'b1;
      end else if (item_done) begin
        hold_valid <= 1'b0;
      end
      if (advance) begin
        step      <= res.last ? 3'd0 : 3'(step + 3'd1);
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      // state changes once the item's final result is out
      if (item_done) begin
        st <= st_next;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          nfcs_pkg::REG_BUS_WIDTH: cfg.bus_width        <= cfg_data[1:0];
          nfcs_pkg::REG_DEV_SIZE:  cfg.device_size_log2 <= cfg_data[4:0];
          nfcs_pkg::REG_TIMEOUT:   cfg.timeout_limit    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hold <= in_item;
    end
    if (advance) begin
      out <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out.bus_data, out.bus_addr};
  assign m_tuser  = {out.status, out.bus_write};
  assign m_tlast  = out.last;

endmodule

`default_nettype wire

### sv/nfcs_step.sv
// result generator: one result of the held item at a given step, plus the
// state the item leaves behind; depends on nfcs_pkg
`default_nettype none

module nfcs_step (
  input  nfcs_pkg::item_t   item,
  input  logic [2:0]        step,
  input  nfcs_pkg::cfg_t    cfg,
  input  nfcs_pkg::state_t  st,
  output nfcs_pkg::result_t res,
  output nfcs_pkg::state_t  st_next
);

  function automatic logic [31:0] repl(input logic [1:0] bw, input logic [7:0] b);
    case (bw)
      nfcs_pkg::BW_8:  return {24'h0, b};
      nfcs_pkg::BW_16: return {16'h0, b, b};
      default:         return {4{b}};
    endcase
  endfunction

  function automatic logic [31:0] wmask(input logic [1:0] bw);
    case (bw)
      nfcs_pkg::BW_8:  return 32'h0000_00ff;
      nfcs_pkg::BW_16: return 32'h0000_ffff;
      default:         return 32'hffff_ffff;
    endcase
  endfunction

  logic        no_device;
  logic        bad_width;
  logic [31:0] mask;
  logic        match;

  assign no_device = (cfg.device_size_log2 == 5'd0);
  assign bad_width = (cfg.bus_width > nfcs_pkg::BW_32);
  assign mask      = wmask(cfg.bus_width);
  assign match     = ((item.read_first & mask) == (st.expected_value & mask)) &&
                     ((item.read_second & mask) == (st.expected_value & mask));

  always_comb begin
    res       = '0;
    res.last  = 1'b1;
    st_next   = st;
    case (item.mode)
      nfcs_pkg::MODE_RESET: begin
        st_next.kind = nfcs_pkg::KIND_NONE;
        if (bad_width) begin
          res.status = nfcs_pkg::ST_DONE;
        end else begin
          res.bus_write = 1'b1;
          res.bus_data  = repl(cfg.bus_width, 8'hf0);
          res.status    = nfcs_pkg::ST_ISSUED;
        end
      end
      nfcs_pkg::MODE_CHIP_ERASE: begin
        if (no_device || bad_width) begin
          res.status = nfcs_pkg::ST_REFUSED;
        end else begin
          res.bus_write = 1'b1;
          res.status    = nfcs_pkg::ST_ISSUED;
          res.last      = (step == 3'd5);
          case (step)
            3'd0, 3'd3: begin
              res.bus_addr = nfcs_pkg::ADDR_UNLOCK1;
              res.bus_data = repl(cfg.bus_width, 8'haa);
            end
            3'd1, 3'd4: begin
              res.bus_addr = nfcs_pkg::ADDR_UNLOCK2;
              res.bus_data = repl(cfg.bus_width, 8'h55);
            end
            3'd2: begin
              res.bus_addr = nfcs_pkg::ADDR_UNLOCK1;
              res.bus_data = repl(cfg.bus_width, 8'h80);
            end
            default: begin
              res.bus_addr = nfcs_pkg::ADDR_UNLOCK1;
              res.bus_data = repl(cfg.bus_width, 8'h10);
            end
          endcase
          st_next = '{kind: nfcs_pkg::KIND_ERASE, expected_value: mask,
                      poll_count: 24'd0, poll_address: '0};
        end
      end
      nfcs_pkg::MODE_SECT_ERASE, nfcs_pkg::MODE_PROGRAM: begin
        if (no_device) begin
          res.status = nfcs_pkg::ST_REFUSED;
        end else if (cfg.bus_width != nfcs_pkg::BW_16) begin
          res.status = nfcs_pkg::ST_DONE;
        end else if (item.mode == nfcs_pkg::MODE_SECT_ERASE) begin
          res.bus_write = 1'b1;
          res.status    = nfcs_pkg::ST_ISSUED;
          res.last      = (step == 3'd5);
          case (step)
            3'd0, 3'd3: begin
              res.bus_addr = nfcs_pkg::ADDR_UNLOCK1;
              res.bus_data = 32'h0000_aaaa;
            end
            3'd1, 3'd4: begin
              res.bus_addr = nfcs_pkg::ADDR_UNLOCK2;
              res.bus_data = 32'h0000_5555;
            end
            3'd2: begin
              res.bus_addr = nfcs_pkg::ADDR_UNLOCK1;
              res.bus_data = 32'h0000_8080;
            end
            default: begin
              res.bus_addr = item.word;
              res.bus_data = 32'h0000_3030;
            end
          endcase
          st_next = '{kind: nfcs_pkg::KIND_ERASE, expected_value: 32'h0000_ffff,
                      poll_count: 24'd0, poll_address: item.word};
        end else begin
          res.bus_write = 1'b1;
          res.status    = nfcs_pkg::ST_ISSUED;
          res.last      = (step == 3'd3);
          case (step)
            3'd0: begin
              res.bus_addr = nfcs_pkg::ADDR_UNLOCK1;
              res.bus_data = 32'h0000_aaaa;
            end
            3'd1: begin
              res.bus_addr = nfcs_pkg::ADDR_UNLOCK2;
              res.bus_data = 32'h0000_5555;
            end
            3'd2: begin
              res.bus_addr = nfcs_pkg::ADDR_UNLOCK1;
              res.bus_data = 32'h0000_a0a0;
            end
            default: begin
              res.bus_addr = item.word;
              res.bus_data = {16'h0, item.write_data};
            end
          endcase
          st_next = '{kind: nfcs_pkg::KIND_PROGRAM,
                      expected_value: {16'h0, item.write_data},
                      poll_count: 24'd0, poll_address: item.word};
        end
      end
      nfcs_pkg::MODE_POLL: begin
        if (st.kind == nfcs_pkg::KIND_NONE) begin
          res.status = nfcs_pkg::ST_IDLE;
        end else if (st.poll_count > cfg.timeout_limit) begin
          res.bus_addr = st.poll_address;
          res.status   = nfcs_pkg::ST_TIMEOUT;
          st_next.kind = nfcs_pkg::KIND_NONE;
        end else begin
          res.bus_addr = st.poll_address;
          if (st.poll_count != nfcs_pkg::ADDR_MAX) begin
            st_next.poll_count = st.poll_count + 24'd1;
          end
          if (match) begin
            res.status   = nfcs_pkg::ST_DONE;
            st_next.kind = nfcs_pkg::KIND_NONE;
          end else begin
            res.status = nfcs_pkg::ST_BUSY;
          end
        end
      end
      default: begin
        res.status = nfcs_pkg::ST_REFUSED;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/nfcs_checker.sv
// port-level checks of the nor flash command sequencer, bound to the top
// level; depends on nfcs_pkg and nor_flash_command_sequencer_macros.svh
`default_nettype none
`include "nor_flash_command_sequencer_macros.svh"

module nfcs_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [55:0]  m_tdata,
  input logic [3:0]   m_tuser,
  input logic         m_tlast
);

  // a stalled result holds
  `NFCS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // m_tvalid is always high by the time an accepted item could pass the item and result registers
  `NFCS_ASSERT_IMPL(a_flow, s_tvalid && s_tready, ##2 m_tvalid)

  // only bus writes are followed by more results of the same item
  `NFCS_ASSERT_IMPL(a_run, m_tvalid && !m_tlast, m_tuser[0])

  // issued status goes with bus writes and nothing else
  `NFCS_ASSERT_IMPL(a_issue, m_tvalid, m_tuser[0] == (m_tuser[3:1] == nfcs_pkg::ST_ISSUED))

endmodule

bind nor_flash_command_sequencer nfcs_checker u_nfcs_checker (.*);

`default_nettype wire
